// ----- hdl/u8d_pkg.sv -----
// package: types, codes and tables of the utf-8 stream decoder
`default_nettype none

package u8d_pkg;

    localparam int COUNT_BITS = 32;
    localparam int OUT_BITS   = 32;
    localparam int CP_BITS    = 21;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [3:0]            dfa_state_t;
    typedef logic [3:0]            byte_class_t;

    localparam logic [1:0] STATUS_PENDING   = 2'd0;
    localparam logic [1:0] STATUS_DONE      = 2'd1;
    localparam logic [1:0] STATUS_INVALID   = 2'd2;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd3;

    localparam dfa_state_t DFA_ACCEPT = 4'd0;
    localparam dfa_state_t DFA_REJECT = 4'd1;
    localparam dfa_state_t DFA_LAST   = 4'd8;

    localparam logic [CP_BITS-1:0] CP_MAX = 21'h10FFFF;
    localparam logic [CP_BITS-1:0] SURROGATE_LO = 21'h00D800;
    localparam logic [CP_BITS-1:0] SURROGATE_HI = 21'h00DFFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_string;
    } byte_beat_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [CP_BITS-1:0] codepoint;
        logic [OUT_BITS-1:0] codepoint_count;
        logic [OUT_BITS-1:0] bytes_seen;
        logic               string_done;
    } result_beat_t;

    // row = state, column = byte class
    localparam dfa_state_t NEXT_STATE [0:143] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1,
        4'd1, 4'd1, 4'd4, 4'd6, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0,
        4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2,
        4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2,
        4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3,
        4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3,
        4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
        4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1
    };

    function automatic byte_class_t byte_class(input logic [7:0] b);
        byte_class_t cls;
        unique case (b) inside
            [8'h00:8'h7F]: cls = 4'd0;
            [8'h80:8'h8F]: cls = 4'd1;
            [8'h90:8'h9F]: cls = 4'd9;
            [8'hA0:8'hBF]: cls = 4'd7;
            [8'hC0:8'hC1]: cls = 4'd8;
            [8'hC2:8'hDF]: cls = 4'd2;
            8'hE0:         cls = 4'd10;
            [8'hE1:8'hEC]: cls = 4'd3;
            8'hED:         cls = 4'd4;
            [8'hEE:8'hEF]: cls = 4'd3;
            8'hF0:         cls = 4'd11;
            [8'hF1:8'hF3]: cls = 4'd6;
            8'hF4:         cls = 4'd5;
            default:       cls = 4'd8;
        endcase
        return cls;
    endfunction

    function automatic count_t sat_inc(input count_t v);
        return (v == {COUNT_BITS{1'b1}}) ? v : v + count_t'(1);
    endfunction

    function automatic logic [OUT_BITS-1:0] to_out(input count_t v);
        return ((v >> OUT_BITS) != '0) ? {OUT_BITS{1'b1}} : OUT_BITS'(v);
    endfunction

endpackage

`default_nettype wire

// ----- hdl/u8d_core.sv -----
// dfa state, partial codepoint and counters of the utf-8 decoder
`default_nettype none

module u8d_core (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   step,
    input  wire u8d_pkg::byte_beat_t beat,
    output u8d_pkg::result_beat_t result
);
    import u8d_pkg::*;

    dfa_state_t          dfa_state_reg, dfa_state_next;
    logic [CP_BITS-1:0]  partial_reg, partial_next;
    count_t              count_reg, count_next;
    count_t              bytes_reg, bytes_next;

    dfa_state_t          st_eff;
    byte_class_t         cls;
    logic [7:0]          low_mask;

    always_comb
    begin
        st_eff   = (dfa_state_reg > DFA_LAST) ? DFA_REJECT : dfa_state_reg;
        cls      = byte_class(beat.data_byte);
        low_mask = 8'hFF >> cls;

        if (st_eff != DFA_ACCEPT)
            partial_next = {partial_reg[CP_BITS-7:0], beat.data_byte[5:0]};
        else
            partial_next = CP_BITS'(low_mask & beat.data_byte);

        dfa_state_next = NEXT_STATE[{st_eff, cls}];
        bytes_next     = sat_inc(bytes_reg);
        count_next     = (dfa_state_next == DFA_ACCEPT) ? sat_inc(count_reg) : count_reg;

        result.codepoint = '0;
        if (dfa_state_next == DFA_REJECT)
            result.status = STATUS_INVALID;
        else if (dfa_state_next == DFA_ACCEPT)
        begin
            result.status    = STATUS_DONE;
            result.codepoint = partial_next;
        end
        else if (beat.end_of_string)
            result.status = STATUS_TRUNCATED;
        else
            result.status = STATUS_PENDING;

        result.codepoint_count = to_out(count_next);
        result.bytes_seen      = to_out(bytes_next);
        result.string_done     = beat.end_of_string;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dfa_state_reg <= DFA_ACCEPT;
            partial_reg   <= '0;
            count_reg     <= '0;
            bytes_reg     <= '0;
        end
        else if (step)
        begin
            if (beat.end_of_string)
            begin
                dfa_state_reg <= DFA_ACCEPT;
                partial_reg   <= '0;
                count_reg     <= '0;
                bytes_reg     <= '0;
            end
            else
            begin
                dfa_state_reg <= dfa_state_next;
                partial_reg   <= partial_next;
                count_reg     <= count_next;
                bytes_reg     <= bytes_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/utf8_stream_decoder.sv -----
// top level of the utf-8 stream decoder
//
// byte channel: byte_valid / byte_stall / byte_beat carry one raw byte and an
// end-of-string mark; a beat is taken at a rising edge with valid high and
// stall low. result channel: result_valid / result_stall / result_beat give
// one result per byte: status, codepoint, codepoint count, byte count and
// end-of-string flag. a taken byte is held in the input register, then
// decoded into the result register when the result channel is free.
// throughput: one byte per cycle while the result channel is not stalled,
// set by the single feedback path through the dfa table and counters.
// a stalled result holds in the result register; the input register keeps
// accepting until it too is full, then byte_stall rises in the same cycle.
// reset clears both valid flags, the dfa state and the counters; the byte
// with end-of-string set returns the state to accept for the next string.
`default_nettype none

module utf8_stream_decoder (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   byte_valid,
    output logic                  byte_stall,
    input  wire u8d_pkg::byte_beat_t byte_beat,
    output logic                  result_valid,
    input  wire                   result_stall,
    output u8d_pkg::result_beat_t result_beat
);
    import u8d_pkg::*;

    logic         s1_valid_reg;
    byte_beat_t   s1_beat_reg;
    logic         result_valid_reg;
    result_beat_t result_beat_reg;
    result_beat_t core_result;

    logic out_free;
    logic load_s1;
    logic step;

    assign out_free   = !result_valid_reg || !result_stall;
    assign step       = s1_valid_reg && out_free;
    assign byte_stall = s1_valid_reg && !out_free;
    assign load_s1    = byte_valid && !byte_stall;

    u8d_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .beat   (s1_beat_reg),
        .result (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_s1)
                s1_valid_reg <= 1'b1;
            else if (step)
                s1_valid_reg <= 1'b0;

            if (step)
                result_valid_reg <= 1'b1;
            else if (out_free)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_s1)
            s1_beat_reg <= byte_beat;
        if (step)
            result_beat_reg <= core_result;
    end

    assign result_valid = result_valid_reg;
    assign result_beat  = result_beat_reg;

endmodule

`default_nettype wire

// ----- hdl/u8d_checker.sv -----
// port-level assertions for the utf-8 stream decoder and their bind
`default_nettype none

module u8d_checker (
    input wire                   clk,
    input wire                   rst_n,
    input wire                   byte_valid,
    input wire                   byte_stall,
    input wire u8d_pkg::byte_beat_t byte_beat,
    input wire                   result_valid,
    input wire                   result_stall,
    input wire u8d_pkg::result_beat_t result_beat
);
    import u8d_pkg::*;

    // stalled result beat holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_beat))
        else $error("result beat changed while stalled");

    // a completed codepoint is a unicode scalar value
    a_scalar: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_beat.status == STATUS_DONE |->
            result_beat.codepoint <= CP_MAX &&
            !(result_beat.codepoint >= SURROGATE_LO &&
              result_beat.codepoint <= SURROGATE_HI))
        else $error("completed codepoint out of range");

    // truncation only on the last byte of a string
    a_trunc_end: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_beat.status == STATUS_TRUNCATED |->
            result_beat.string_done)
        else $error("truncated status before end of string");

    // codepoint is zero unless one completes
    a_cp_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_beat.status != STATUS_DONE |->
            result_beat.codepoint == '0)
        else $error("codepoint set without completion");

    // never more codepoints than bytes
    a_count_le: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result_beat.codepoint_count <= result_beat.bytes_seen)
        else $error("codepoint count above byte count");

endmodule

bind utf8_stream_decoder u8d_checker u_checker (.*);

`default_nettype wire
